/* hdl/assert_macros.svh */
// assertion macros used by eft_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define EFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/eft_pkg.sv */
// types and constants of the ethertype filter table
// no dependencies
package eft_pkg;

    localparam int MAX_TYPES_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int TYPE_W   = 16;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 16;
    localparam int CODE_W   = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_CONNECT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY   = 2'd2;

    localparam logic [CODE_W-1:0] RES_OK      = 2'd0;
    localparam logic [CODE_W-1:0] RES_REFUSED = 2'd1;
    localparam logic [CODE_W-1:0] RES_BAD     = 2'd2;

    localparam logic [STATUS_W-1:0] BAD_MASK_RST = 16'h0001;

    typedef struct packed {
        logic [TYPE_W-1:0] ether_type;
        logic [TAG_W-1:0]  handler;
    } t_slot;

endpackage

/* hdl/ethertype_filter_table.sv */
// ethertype filter table: slot table memory, one shared compare unit, scan sequencer
// depends on eft_pkg
//
// Every command (connect, disconnect, classify) scans all MAX_TYPES slots, one
// slot per cycle read from the registered table memory and checked by the
// single compare unit, then finishes in its own state: busy stays high through
// the scan and the finish. The result is shown for exactly one cycle with
// o_result_stb, in the first cycle busy is low again, and a new command may
// start in that same cycle, so no new command is taken before the last one has
// finished. The receiver cannot stall the result. o_cfg_ready stays high and
// the mask register is sampled when a command finishes, so write it only while
// busy is low.
module ethertype_filter_table #(
    parameter int MAX_TYPES = eft_pkg::MAX_TYPES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [eft_pkg::CMD_W-1:0]     i_cmd,
    input  logic [eft_pkg::TYPE_W-1:0]    i_ether_type,
    input  logic [eft_pkg::TAG_W-1:0]     i_handler_tag,
    input  logic [eft_pkg::STATUS_W-1:0]  i_rx_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [eft_pkg::STATUS_W-1:0]  i_cfg_bad_status_mask,
    output logic                          o_result_stb,
    output logic [eft_pkg::CODE_W-1:0]    o_result_code,
    output logic [eft_pkg::TAG_W-1:0]     o_matched_handler,
    output logic [eft_pkg::COUNT_W-1:0]   o_entries_used
);

    localparam int IW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int CW = $clog2(MAX_TYPES + 1);
    localparam logic [IW-1:0] LAST = IW'(MAX_TYPES - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state, n_state;

    // command beat
    logic [eft_pkg::CMD_W-1:0]    r_cmd;
    logic [eft_pkg::TYPE_W-1:0]   r_type;
    logic [eft_pkg::TAG_W-1:0]    r_tag;
    logic [eft_pkg::STATUS_W-1:0] r_status;
    logic [eft_pkg::STATUS_W-1:0] r_bad_mask;

    // table
    eft_pkg::t_slot r_mem [MAX_TYPES];
    logic [MAX_TYPES-1:0] r_valid;
    logic [CW-1:0]        r_count;

    // scan pipeline
    logic           r_issue;
    logic [IW-1:0]  r_idx;
    logic           r_rd_vld;
    logic [IW-1:0]  r_rd_idx;
    eft_pkg::t_slot r_rd;

    logic                      r_found;
    logic [IW-1:0]             r_found_idx;
    logic [eft_pkg::TAG_W-1:0] r_hit_handler;
    logic                      r_free;
    logic [IW-1:0]             r_free_idx;

    // result
    logic                       r_out_stb;
    logic [eft_pkg::CODE_W-1:0] r_out_code;
    logic [eft_pkg::TAG_W-1:0]  r_out_handler;
    logic [CW-1:0]              r_out_count;

    logic [eft_pkg::CODE_W-1:0] n_out_code;
    logic [eft_pkg::TAG_W-1:0]  n_out_handler;
    logic [CW-1:0]              n_out_count;

    logic                       n_code_ok_conn;
    logic                       n_code_ok_disc;
    logic                       n_bad;
    logic                       n_hit;
    logic                       n_empty;
    logic [CW+eft_pkg::COUNT_W-1:0] cnt_ext;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign n_hit   = r_rd_vld && r_valid[r_rd_idx] && (r_rd.ether_type == r_type);
    assign n_empty = r_rd_vld && !r_valid[r_rd_idx];

    assign n_code_ok_conn = !r_found && r_free;
    assign n_code_ok_disc = r_found;
    assign n_bad          = (r_status & r_bad_mask) != '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_vld && (r_rd_idx == LAST)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result of the finishing command
    always_comb begin
        n_out_code    = eft_pkg::RES_REFUSED;
        n_out_handler = '0;
        n_out_count   = r_count;
        case (r_cmd)
            eft_pkg::CMD_CONNECT: begin
                if (n_code_ok_conn) begin
                    n_out_code  = eft_pkg::RES_OK;
                    n_out_count = r_count + CW'(1);
                end
            end
            eft_pkg::CMD_DISCONNECT: begin
                if (n_code_ok_disc) begin
                    n_out_code = eft_pkg::RES_OK;
                    if (r_count != '0) begin
                        n_out_count = r_count - CW'(1);
                    end
                end
            end
            eft_pkg::CMD_CLASSIFY: begin
                if (n_bad) begin
                    n_out_code = eft_pkg::RES_BAD;
                end else if (r_found) begin
                    n_out_code    = eft_pkg::RES_OK;
                    n_out_handler = r_hit_handler;
                end
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_free     <= 1'b0;
            r_valid    <= '0;
            r_count    <= '0;
            r_out_stb  <= 1'b0;
            r_bad_mask <= eft_pkg::BAD_MASK_RST;
        end else begin
            r_state   <= n_state;
            r_out_stb <= (r_state == S_FINISH);
            if (i_cfg_valid) begin
                r_bad_mask <= i_cfg_bad_status_mask;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_issue <= 1'b1;
                        r_found <= 1'b0;
                        r_free  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= r_issue;
                    if (r_issue && (r_idx == LAST)) begin
                        r_issue <= 1'b0;
                    end
                    if (n_hit && !r_found) begin
                        r_found <= 1'b1;
                    end
                    if (n_empty && !r_free) begin
                        r_free <= 1'b1;
                    end
                end
                S_FINISH: begin
                    r_rd_vld <= 1'b0;
                    r_count  <= n_out_count;
                    case (r_cmd)
                        eft_pkg::CMD_CONNECT: begin
                            if (n_code_ok_conn) begin
                                r_valid[r_free_idx] <= 1'b1;
                            end
                        end
                        eft_pkg::CMD_DISCONNECT: begin
                            if (n_code_ok_disc) begin
                                r_valid[r_found_idx] <= 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_cmd    <= i_cmd;
            r_type   <= i_ether_type;
            r_tag    <= i_handler_tag;
            r_status <= i_rx_status;
            r_idx    <= '0;
        end else if ((r_state == S_SCAN) && r_issue && (r_idx != LAST)) begin
            r_idx <= r_idx + IW'(1);
        end
        if (r_state == S_SCAN) begin
            if (n_hit && !r_found) begin
                r_found_idx   <= r_rd_idx;
                r_hit_handler <= r_rd.handler;
            end
            if (n_empty && !r_free) begin
                r_free_idx <= r_rd_idx;
            end
        end
        if (r_state == S_FINISH) begin
            r_out_code    <= n_out_code;
            r_out_handler <= n_out_handler;
            r_out_count   <= n_out_count;
        end
    end

    // slot table memory
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && r_issue) begin
            r_rd     <= r_mem[r_idx];
            r_rd_idx <= r_idx;
        end
        if ((r_state == S_FINISH) && (r_cmd == eft_pkg::CMD_CONNECT) && n_code_ok_conn) begin
            r_mem[r_free_idx] <= '{ether_type: r_type, handler: r_tag};
        end
    end

    assign cnt_ext           = {{eft_pkg::COUNT_W{1'b0}}, r_out_count};
    assign o_result_stb      = r_out_stb;
    assign o_result_code     = r_out_code;
    assign o_matched_handler = r_out_handler;
    assign o_entries_used    = cnt_ext[eft_pkg::COUNT_W-1:0];

endmodule

/* hdl/eft_checker.sv */
// port-level checks of the ethertype filter table, bound to ethertype_filter_table
// depends on eft_pkg and assert_macros.svh
`include "assert_macros.svh"

module eft_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_result_stb,
    input logic [eft_pkg::CODE_W-1:0]    o_result_code,
    input logic [eft_pkg::TAG_W-1:0]     o_matched_handler
);

    // a taken command engages the sequencer
    `EFT_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)

    // every command ends in a result beat
    `EFT_ASSERT_IMP(a_end_beat, i_clk, i_rst_n, $fell(busy), o_result_stb)

    // no result beat while a command is in flight, nor two result beats in a row
    `EFT_ASSERT_IMP(a_beat_idle, i_clk, i_rst_n, o_result_stb, !busy && !$past(o_result_stb))

    // handler only reported on a match
    `EFT_ASSERT_IMP(a_handler_zero, i_clk, i_rst_n, o_result_stb && (o_result_code != eft_pkg::RES_OK), o_matched_handler == '0)

endmodule

bind ethertype_filter_table eft_checker u_eft_checker (.*);

/* bench/ethertype_filter_checker.sv */
`timescale 1ns / 1ps
// checker for the ethertype filter table: predicts every command beat and compares results
// depends on eft_pkg; instantiated by tb_ethertype_filter_table
module ethertype_filter_checker #(
    parameter int NUM_SLOTS = eft_pkg::MAX_TYPES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [eft_pkg::CMD_W-1:0]     i_cmd,
    input  logic [eft_pkg::TYPE_W-1:0]    i_ether_type,
    input  logic [eft_pkg::TAG_W-1:0]     i_handler_tag,
    input  logic [eft_pkg::STATUS_W-1:0]  i_rx_status,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [eft_pkg::STATUS_W-1:0]  i_cfg_mask,
    input  logic                          i_result_stb,
    input  logic [eft_pkg::CODE_W-1:0]    i_result_code,
    input  logic [eft_pkg::TAG_W-1:0]     i_matched_handler,
    input  logic [eft_pkg::COUNT_W-1:0]   i_entries_used,
    output int                            o_errors,
    output int                            o_pending
);
    import eft_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [TAG_W-1:0]   handler;
        logic [COUNT_W-1:0] used;
    } t_dispatch_result;

    logic                slot_used    [NUM_SLOTS];
    logic [TYPE_W-1:0]   slot_type    [NUM_SLOTS];
    logic [TAG_W-1:0]    slot_handler [NUM_SLOTS];
    logic [COUNT_W-1:0]  used_slots;
    logic [STATUS_W-1:0] bad_mask;
    t_dispatch_result    expected_results [$];

    function automatic int find_type(input logic [TYPE_W-1:0] t);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_used[i] && slot_type[i] == t) return i;
        end
        return NUM_SLOTS;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_used[i]) return i;
        end
        return NUM_SLOTS;
    endfunction

    // applies one command to the shadow table and returns the result it should give
    function automatic t_dispatch_result dispatch_predict(
        input logic [CMD_W-1:0]    cmd,
        input logic [TYPE_W-1:0]   t,
        input logic [TAG_W-1:0]    tag,
        input logic [STATUS_W-1:0] st
    );
        t_dispatch_result r;
        int s;
        r.code    = RES_REFUSED;
        r.handler = '0;
        case (cmd)
            CMD_CONNECT: begin
                if (find_type(t) == NUM_SLOTS) begin
                    s = find_free();
                    if (s < NUM_SLOTS) begin
                        slot_used[s]    = 1'b1;
                        slot_type[s]    = t;
                        slot_handler[s] = tag;
                        used_slots      = used_slots + COUNT_W'(1);
                        r.code          = RES_OK;
                    end
                end
            end
            CMD_DISCONNECT: begin
                s = find_type(t);
                if (s < NUM_SLOTS) begin
                    slot_used[s] = 1'b0;
                    if (used_slots != '0) used_slots = used_slots - COUNT_W'(1);
                    r.code = RES_OK;
                end
            end
            CMD_CLASSIFY: begin
                if ((st & bad_mask) != '0) begin
                    r.code = RES_BAD;
                end else begin
                    s = find_type(t);
                    if (s < NUM_SLOTS) begin
                        r.code    = RES_OK;
                        r.handler = slot_handler[s];
                    end
                end
            end
            default: ;
        endcase
        r.used = used_slots;
        return r;
    endfunction

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_dispatch_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) slot_used[i] = 1'b0;
            used_slots = '0;
            bad_mask   = BAD_MASK_RST;
            expected_results.delete();
        end else begin
            // a result beat belongs to an older command than one started at this edge
            if (i_result_stb) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, code %0d handler %0d used %0d",
                             $time, i_result_code, i_matched_handler, i_entries_used);
                    o_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    report_field("result_code", int'(exp_r.code), int'(i_result_code));
                    report_field("matched_handler", int'(exp_r.handler),
                                 int'(i_matched_handler));
                    report_field("entries_used", int'(exp_r.used), int'(i_entries_used));
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(
                    dispatch_predict(i_cmd, i_ether_type, i_handler_tag, i_rx_status));
            if (i_cfg_valid && i_cfg_ready) bad_mask = i_cfg_mask;
        end
        o_pending = expected_results.size();
    end

endmodule

/* bench/tb_ethertype_filter_table.sv */
`timescale 1ns / 1ps
// top of the ethertype filter table bench: clock, reset, command and mask stimulus, verdict
// depends on eft_pkg, ethertype_filter_table and ethertype_filter_checker
module tb_ethertype_filter_table;
    import eft_pkg::*;

    localparam int NUM_SLOTS    = MAX_TYPES_DEF;
    localparam int POOL_SIZE    = 24;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 80;
    localparam int DRAIN_CYCLES = NUM_SLOTS + 6;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    i_cmd;
    logic [TYPE_W-1:0]   i_ether_type;
    logic [TAG_W-1:0]    i_handler_tag;
    logic [STATUS_W-1:0] i_rx_status;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [STATUS_W-1:0] i_cfg_bad_status_mask;
    logic                o_result_stb;
    logic [CODE_W-1:0]   o_result_code;
    logic [TAG_W-1:0]    o_matched_handler;
    logic [COUNT_W-1:0]  o_entries_used;

    int                  error_count;
    int                  pending_count;
    logic                idle_enable;
    logic [STATUS_W-1:0] current_mask;
    logic [TYPE_W-1:0]   type_pool [POOL_SIZE];

    ethertype_filter_table #(.MAX_TYPES(NUM_SLOTS)) u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_cmd                 (i_cmd),
        .i_ether_type          (i_ether_type),
        .i_handler_tag         (i_handler_tag),
        .i_rx_status           (i_rx_status),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_bad_status_mask (i_cfg_bad_status_mask),
        .o_result_stb          (o_result_stb),
        .o_result_code         (o_result_code),
        .o_matched_handler     (o_matched_handler),
        .o_entries_used        (o_entries_used)
    );

    ethertype_filter_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_cmd             (i_cmd),
        .i_ether_type      (i_ether_type),
        .i_handler_tag     (i_handler_tag),
        .i_rx_status       (i_rx_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_mask        (i_cfg_bad_status_mask),
        .i_result_stb      (o_result_stb),
        .i_result_code     (o_result_code),
        .i_matched_handler (o_matched_handler),
        .i_entries_used    (o_entries_used),
        .o_errors          (error_count),
        .o_pending         (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_command(
        input logic [CMD_W-1:0]    cmd,
        input logic [TYPE_W-1:0]   t,
        input logic [TAG_W-1:0]    tag,
        input logic [STATUS_W-1:0] st
    );
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         = 1'b1;
        i_cmd         = cmd;
        i_ether_type  = t;
        i_handler_tag = tag;
        i_rx_status   = st;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_mask(input logic [STATUS_W-1:0] value);
        wait_drained();
        i_cfg_valid           = 1'b1;
        i_cfg_bad_status_mask = value;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid  = 1'b0;
        current_mask = value;
    endtask

    function automatic logic [TYPE_W-1:0] pick_type();
        if ($urandom_range(0, 4) != 0) return type_pool[$urandom_range(0, POOL_SIZE - 1)];
        return TYPE_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return CMD_CONNECT;
        if (roll < 55) return CMD_DISCONNECT;
        if (roll < 95) return CMD_CLASSIFY;
        return CMD_UNUSED;
    endfunction

    initial begin
        logic [STATUS_W-1:0] phase_mask [PHASES];
        logic [STATUS_W-1:0] st;

        start                 = 1'b0;
        i_rst_n               = 1'b0;
        i_cmd                 = CMD_CONNECT;
        i_ether_type          = '0;
        i_handler_tag         = '0;
        i_rx_status           = '0;
        i_cfg_valid           = 1'b0;
        i_cfg_bad_status_mask = '0;
        idle_enable           = 1'b1;
        current_mask          = BAD_MASK_RST;

        type_pool[0] = 16'h0000;
        type_pool[1] = 16'hFFFF;
        for (int k = 2; k < POOL_SIZE; k++) type_pool[k] = TYPE_W'(32'h0800 + k * 32'h0111);

        phase_mask[0] = BAD_MASK_RST;
        phase_mask[1] = 16'h0000;
        phase_mask[2] = 16'hFFFF;
        phase_mask[3] = STATUS_W'($urandom & $urandom);
        phase_mask[4] = 16'h8000;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: extremes, duplicates, bad frames, unknown command, full table
        send_command(CMD_CONNECT, type_pool[0], 8'hFF, 16'h0000);
        send_command(CMD_CONNECT, type_pool[1], 8'h00, 16'hFFFF);
        send_command(CMD_CONNECT, type_pool[0], 8'h5A, 16'h0000);
        send_command(CMD_CLASSIFY, type_pool[1], 8'h00, 16'h0000);
        send_command(CMD_CLASSIFY, type_pool[0], 8'h00, 16'hFFFE);
        send_command(CMD_CLASSIFY, type_pool[0], 8'h00, 16'h0001);
        send_command(CMD_CLASSIFY, 16'h1234, 8'hFF, 16'h0000);
        send_command(CMD_DISCONNECT, 16'h1234, 8'h00, 16'h0000);
        send_command(CMD_UNUSED, type_pool[0], 8'hFF, 16'hFFFF);
        for (int k = 2; k < NUM_SLOTS; k++)
            send_command(CMD_CONNECT, type_pool[k], TAG_W'($urandom), STATUS_W'($urandom));
        send_command(CMD_CONNECT, type_pool[NUM_SLOTS], 8'hA5, 16'h0000);
        send_command(CMD_DISCONNECT, type_pool[0], 8'h00, 16'h0000);
        send_command(CMD_CONNECT, type_pool[NUM_SLOTS], 8'hC3, 16'h0000);
        send_command(CMD_CLASSIFY, type_pool[NUM_SLOTS], 8'h00, 16'h0000);

        // random phases, one mask setting each, no idling in the last one
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) write_mask(phase_mask[p]);
            idle_enable = (p < PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                st = STATUS_W'($urandom);
                if ($urandom_range(0, 1) == 0) st = st & ~current_mask;
                send_command(pick_cmd(), pick_type(), TAG_W'($urandom), st);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* ethertype_filter_table.f */
+incdir+hdl
hdl/eft_pkg.sv
hdl/ethertype_filter_table.sv
hdl/eft_checker.sv
bench/ethertype_filter_checker.sv
bench/tb_ethertype_filter_table.sv
